[hdl/rcba_pkg.sv]
package rcba_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int OFFSET_BITS = 24;
  localparam int ID_BITS     = 32;
  localparam int SIZE_BITS   = 24;
  localparam int CAP_BITS    = 24;
  localparam int REFS_BITS   = 16;
  localparam int CAP_RESET   = 65536;

  // wide enough for free pointer plus request without overflow
  localparam int SUM_W = ((OFFSET_BITS > CAP_BITS) ? OFFSET_BITS : CAP_BITS) + 1;
  localparam int CNT_W = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;

  localparam int IN_DATA_W  = ((ID_BITS + SIZE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ID_BITS + OFFSET_BITS + 1 + OFFSET_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_ADDREF  = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_COMPACT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_NO_SPACE   = 2'd1,
    STS_UNKNOWN_ID = 2'd2,
    STS_TABLE_FULL = 2'd3
  } status_t;

  // operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_STEP,
    OP_PLACE,
    OP_CREATE,
    OP_ADDREF,
    OP_RELEASE
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [ID_BITS-1:0]     key;
    logic [OFFSET_BITS-1:0] off;
    logic [SIZE_BITS-1:0]   size;
    logic                   use_free;
  } bcast_t;

  // search token passed from cell to cell
  typedef struct packed {
    logic valid;
    logic match;
    logic free;
    logic last_ref;
  } tok_t;

  // entry copy rotated around the ring during compaction
  typedef struct packed {
    logic                   valid;
    logic [OFFSET_BITS-1:0] off;
    logic [SIZE_BITS-1:0]   size;
  } ring_t;

endpackage

[hdl/rcba_cell.sv]
module rcba_cell (
  input  logic            clk,
  input  logic            rst,
  input  rcba_pkg::bcast_t bc,
  input  rcba_pkg::tok_t  tok_in,
  output rcba_pkg::tok_t  tok_out,
  input  rcba_pkg::ring_t ring_in,
  output rcba_pkg::ring_t ring_out
);
  import rcba_pkg::*;

  logic                   valid;
  logic [ID_BITS-1:0]     id;
  logic [OFFSET_BITS-1:0] off;
  logic [SIZE_BITS-1:0]   size;
  logic [REFS_BITS-1:0]   refs;
  logic                   sel_match;
  logic                   sel_free;
  logic [OFFSET_BITS-1:0] acc;
  ring_t                  ring;
  tok_t                   tok;

  logic hit;
  logic one_left;

  assign hit      = valid && (id == bc.key);
  assign one_left = (refs <= REFS_BITS'(1));
  assign tok_out  = tok;
  assign ring_out = ring;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      tok.valid <= 1'b0;
    end else begin
      // token moves one cell per cycle
      tok.valid    <= tok_in.valid;
      tok.match    <= tok_in.match | hit;
      tok.free     <= tok_in.free | !valid;
      tok.last_ref <= tok_in.last_ref | (hit && !tok_in.match && one_left);
      if (tok_in.valid) begin
        sel_match <= hit && !tok_in.match;
        sel_free  <= !valid && !tok_in.free;
      end

      case (bc.op)
        OP_CREATE: begin
          if (sel_match || (sel_free && bc.use_free)) begin
            valid <= 1'b1;
            id    <= bc.key;
            off   <= bc.off;
            size  <= bc.size;
            refs  <= REFS_BITS'(1);
          end
        end
        OP_ADDREF: begin
          if (sel_match && (refs != '1)) begin
            refs <= refs + REFS_BITS'(1);
          end
        end
        OP_RELEASE: begin
          if (sel_match) begin
            if (refs != '0) begin
              refs <= refs - REFS_BITS'(1);
            end
            if (one_left) begin
              valid <= 1'b0;
            end
          end
        end
        OP_LOAD: begin
          ring.valid <= valid;
          ring.off   <= off;
          ring.size  <= size;
          acc        <= '0;
        end
        OP_STEP: begin
          // add sizes of live blocks lying below this one
          if (ring.valid && (ring.off < off)) begin
            acc <= acc + OFFSET_BITS'(ring.size);
          end
          ring <= ring_in;
        end
        OP_PLACE: begin
          if (valid) begin
            off <= acc;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[hdl/refcounted_bump_allocator.sv]
// Reference-counted bump allocator with handles and compaction.
// Commands arrive as beats on the s_ channel (cmd in s_tuser) and every
// command returns exactly one result beat on the m_ channel (status in
// m_tuser). The cfg channel writes the capacity register; it is always ready
// and is meant to be written only while no command is in flight.
// The entry table is a row of MAX_ENTRIES cells. Lookups for add reference,
// release and create send a token down the row, one cell per cycle.
// A create that does not fit skips the lookup and goes straight to emit.
// Compaction rotates every entry once around the ring of cells, each cell
// summing the sizes that lie below it, then places all blocks at once.
// One command is worked on at a time; the row walk or the ring rotation
// sets the rate.
// A new command is accepted as soon as the previous one has finished, even
// while its result beat still waits in the output register; a stalled
// receiver only holds the block once a second result is ready.
// Reset (rst, synchronous) empties the table, sets the next id to 1, the
// free pointer to 0 and capacity to 65536.
module refcounted_bump_allocator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // block_id [31:0], alloc_size [55:32]
  input  logic [rcba_pkg::IN_DATA_W-1:0]    s_tdata,
  // cmd [1:0]
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // new_id [31:0], block_offset [55:32], freed [56], next_free [80:57]
  output logic [rcba_pkg::OUT_DATA_W-1:0]   m_tdata,
  // status [1:0]
  output logic [1:0]                        m_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rcba_pkg::CAP_BITS-1:0]     cfg_data
);
  import rcba_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_APPLY,
    ST_RING,
    ST_PLACE,
    ST_EMIT
  } state_t;

  state_t                 state;
  cmd_t                   cmd_q;
  logic [ID_BITS-1:0]     key_q;
  logic [SIZE_BITS-1:0]   size_q;
  logic                   use_free_q;
  logic                   last_ref_q;
  logic [CAP_BITS-1:0]    capacity;
  logic [ID_BITS-1:0]     id_counter;
  logic [OFFSET_BITS-1:0] free_pointer;
  logic [OFFSET_BITS-1:0] total;
  logic [CNT_W-1:0]       cnt;
  tok_t                   tok_start;

  status_t                res_status;
  logic [ID_BITS-1:0]     res_id;
  logic [OFFSET_BITS-1:0] res_off;
  logic                   res_freed;

  // input beat fields
  cmd_t                   in_cmd;
  logic [ID_BITS-1:0]     in_id;
  logic [SIZE_BITS-1:0]   in_size;
  logic                   accept;
  logic [SUM_W-1:0]       space_sum;
  logic [SUM_W-1:0]       fp_sum;

  bcast_t                 bc;
  tok_t                   tok_chain  [MAX_ENTRIES];
  ring_t                  ring_chain [MAX_ENTRIES];
  tok_t                   tok_end;
  ring_t                  ring_tap;

  assign in_cmd    = cmd_t'(s_tuser);
  assign in_id     = s_tdata[ID_BITS-1:0];
  assign in_size   = s_tdata[ID_BITS +: SIZE_BITS];
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign space_sum = SUM_W'(free_pointer) + SUM_W'(in_size);
  assign fp_sum    = SUM_W'(free_pointer) + SUM_W'(size_q);

  assign tok_end  = tok_chain[MAX_ENTRIES-1];
  assign ring_tap = ring_chain[0];

  // broadcast to the cells
  always_comb begin
    bc.key      = key_q;
    bc.off      = free_pointer;
    bc.size     = size_q;
    bc.use_free = use_free_q;
    bc.op       = OP_NONE;
    case (state)
      ST_IDLE:  bc.op = (accept && (in_cmd == CMD_COMPACT)) ? OP_LOAD : OP_NONE;
      ST_RING:  bc.op = OP_STEP;
      ST_PLACE: bc.op = OP_PLACE;
      ST_APPLY: begin
        case (cmd_q)
          CMD_CREATE:  bc.op = OP_CREATE;
          CMD_ADDREF:  bc.op = OP_ADDREF;
          CMD_RELEASE: bc.op = OP_RELEASE;
          default:     bc.op = OP_NONE;
        endcase
      end
      default: bc.op = OP_NONE;
    endcase
  end

  // row of entry cells: token runs 0 -> N-1, ring closes back to cell 0
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    rcba_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .bc       (bc),
      .tok_in   ((i == 0) ? tok_start : tok_chain[(i + MAX_ENTRIES - 1) % MAX_ENTRIES]),
      .tok_out  (tok_chain[i]),
      .ring_in  (ring_chain[(i + MAX_ENTRIES - 1) % MAX_ENTRIES]),
      .ring_out (ring_chain[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      m_tvalid     <= 1'b0;
      tok_start    <= '0;
      capacity     <= CAP_BITS'(CAP_RESET);
      id_counter   <= ID_BITS'(1);
      free_pointer <= '0;
    end else begin
      tok_start.valid <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid) begin
        capacity <= cfg_data;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_q      <= in_cmd;
            size_q     <= in_size;
            key_q      <= (in_cmd == CMD_CREATE) ? id_counter : in_id;
            res_status <= STS_OK;
            res_id     <= '0;
            res_off    <= '0;
            res_freed  <= 1'b0;
            if (in_cmd == CMD_COMPACT) begin
              cnt   <= '0;
              total <= '0;
              state <= ST_RING;
            end else if ((in_cmd == CMD_CREATE) &&
                         (space_sum > SUM_W'(capacity))) begin
              res_status <= STS_NO_SPACE;
              state      <= ST_EMIT;
            end else begin
              tok_start <= '{valid: 1'b1, match: 1'b0, free: 1'b0, last_ref: 1'b0};
              state     <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (tok_end.valid) begin
            use_free_q <= !tok_end.match;
            last_ref_q <= tok_end.last_ref;
            if ((cmd_q == CMD_CREATE) && !tok_end.match && !tok_end.free) begin
              res_status <= STS_TABLE_FULL;
              state      <= ST_EMIT;
            end else if ((cmd_q != CMD_CREATE) && !tok_end.match) begin
              res_status <= STS_UNKNOWN_ID;
              state      <= ST_EMIT;
            end else begin
              state <= ST_APPLY;
            end
          end
        end
        ST_APPLY: begin
          if (cmd_q == CMD_CREATE) begin
            res_id       <= key_q;
            res_off      <= free_pointer;
            id_counter   <= id_counter + ID_BITS'(1);
            free_pointer <= fp_sum[OFFSET_BITS-1:0];
          end
          if (cmd_q == CMD_RELEASE) begin
            res_freed <= last_ref_q;
          end
          state <= ST_EMIT;
        end
        ST_RING: begin
          // cell 0 sees every entry once as the ring turns
          if (ring_tap.valid) begin
            total <= total + OFFSET_BITS'(ring_tap.size);
          end
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(MAX_ENTRIES - 1)) begin
            state <= ST_PLACE;
          end
        end
        ST_PLACE: begin
          free_pointer <= total;
          state        <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= OUT_DATA_W'({free_pointer, res_freed, res_off, res_id});
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // the lookup token only leaves the row while a search is waiting for it
  a_tok_in_search: assert property (@(posedge clk) disable iff (rst)
    tok_end.valid |-> (state == ST_SEARCH))
    else $error("search token left the row outside a search");

  // compaction moves the free pointer to the summed live sizes
  a_place_total: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PLACE) |=> (free_pointer == $past(total)))
    else $error("free pointer does not match compacted total");

  // a result beat appears only from the emit step
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_EMIT))
    else $error("result beat raised outside emit");

  // the id counter advances only on a successful create
  a_id_step: assert property (@(posedge clk) disable iff (rst)
    (id_counter != $past(id_counter)) |->
      (($past(state) == ST_APPLY) && ($past(cmd_q) == CMD_CREATE)))
    else $error("id counter moved without a create");

endmodule
